### rtl/core/bdar_pkg.sv
// Shared types and constants for the button debounce / auto-repeat block.
// No dependencies; imported by every module in rtl/core.
package bdar_pkg;

  localparam int TIME_W    = 32;
  localparam int CFG_T_W   = 16;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 8;

  // Register map, word index taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_ACTIVE_LEVEL    = 2'd0,
    REG_DEBOUNCE_TIME   = 2'd1,
    REG_LONG_PRESS_TIME = 2'd2,
    REG_REPEAT_INTERVAL = 2'd3
  } reg_idx_t;

  localparam logic               RST_ACTIVE_LEVEL    = 1'b0;
  localparam logic [CFG_T_W-1:0] RST_DEBOUNCE_TIME   = 16'd20;
  localparam logic [CFG_T_W-1:0] RST_LONG_PRESS_TIME = 16'd500;
  localparam logic [CFG_T_W-1:0] RST_REPEAT_INTERVAL = 16'd100;

  // Step kinds carried on s_tuser
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_INIT   = 1'b1;

  typedef struct packed {
    logic               active_level;
    logic [CFG_T_W-1:0] debounce_time;
    logic [CFG_T_W-1:0] long_press_time;
    logic [CFG_T_W-1:0] repeat_interval;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic              pin_level;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic stable_out;
    logic repeat_res;
    logic released;
    logic pressed;
  } result_t;

endpackage

### rtl/core/bdar_cfg_regs.sv
// APB register file for the debounce / auto-repeat settings.
// Depends on bdar_pkg for the register map, reset values and cfg_t.
module bdar_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdar_pkg::APB_AW-1:0]  paddr,
  input  logic [bdar_pkg::APB_DW-1:0]  pwdata,
  output logic [bdar_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output bdar_pkg::cfg_t               cfg
);
  import bdar_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write on the access phase of a request
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level    <= RST_ACTIVE_LEVEL;
      cfg.debounce_time   <= RST_DEBOUNCE_TIME;
      cfg.long_press_time <= RST_LONG_PRESS_TIME;
      cfg.repeat_interval <= RST_REPEAT_INTERVAL;
    end else if (wr_en) begin
      case (idx)
        REG_ACTIVE_LEVEL:    cfg.active_level    <= pwdata[0];
        REG_DEBOUNCE_TIME:   cfg.debounce_time   <= pwdata[CFG_T_W-1:0];
        REG_LONG_PRESS_TIME: cfg.long_press_time <= pwdata[CFG_T_W-1:0];
        REG_REPEAT_INTERVAL: cfg.repeat_interval <= pwdata[CFG_T_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended
  always_comb begin
    case (idx)
      REG_ACTIVE_LEVEL:    prdata = {{(APB_DW-1){1'b0}}, cfg.active_level};
      REG_DEBOUNCE_TIME:   prdata = {{(APB_DW-CFG_T_W){1'b0}}, cfg.debounce_time};
      REG_LONG_PRESS_TIME: prdata = {{(APB_DW-CFG_T_W){1'b0}}, cfg.long_press_time};
      REG_REPEAT_INTERVAL: prdata = {{(APB_DW-CFG_T_W){1'b0}}, cfg.repeat_interval};
      default:             prdata = '0;
    endcase
  end

endmodule

### rtl/core/bdar_in_reg.sv
// Input register stage: captures one request from the slave stream.
// Depends on bdar_pkg for item_t and the tdata layout.
module bdar_in_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bdar_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  input  logic                           take,
  output logic                           item_valid,
  output bdar_pkg::item_t                item
);
  import bdar_pkg::*;

  // Free when empty or when the held item moves on this cycle
  assign s_tready = !item_valid || take;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.mode      <= s_tuser;
      item.pin_level <= s_tdata[0];
      item.now_ms    <= s_tdata[TIME_W:1];
    end
  end

endmodule

### rtl/core/bdar_core.sv
// Debounce and auto-repeat state update with the result register.
// Depends on bdar_pkg for cfg_t, item_t and result_t.
module bdar_core (
  input  logic                           clk,
  input  logic                           rst,
  input  bdar_pkg::cfg_t                 cfg,
  input  logic                           item_valid,
  input  bdar_pkg::item_t                item,
  output logic                           take,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bdar_pkg::M_TDATA_W-1:0] m_tdata
);
  import bdar_pkg::*;

  logic              raw_level, raw_level_next;
  logic              stable_level, stable_level_next;
  logic [TIME_W-1:0] last_change_time, last_change_time_next;
  logic [TIME_W-1:0] press_time, press_time_next;
  logic [TIME_W-1:0] last_repeat_time, last_repeat_time_next;
  result_t           res, res_next;

  logic              ld;
  logic              lvl_chg;
  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_press;
  logic [TIME_W-1:0] since_repeat;
  logic              settle;
  logic              press_ev, release_ev, rpt_ev;

  // Move the held request when the result slot is free or being drained
  assign take = !m_tvalid || m_tready;
  assign ld   = item_valid && take;

  // Elapsed times, all wrapping; a change this step restarts from zero
  assign lvl_chg      = item.pin_level != raw_level;
  assign since_change = lvl_chg ? '0 : item.now_ms - last_change_time;
  assign since_press  = item.now_ms - press_time;
  assign since_repeat = item.now_ms - last_repeat_time;

  assign settle = (since_change >= {{(TIME_W-CFG_T_W){1'b0}}, cfg.debounce_time}) &&
                  (stable_level != item.pin_level);

  // Next state and events
  always_comb begin
    raw_level_next        = raw_level;
    stable_level_next     = stable_level;
    last_change_time_next = last_change_time;
    press_time_next       = press_time;
    last_repeat_time_next = last_repeat_time;
    press_ev              = 1'b0;
    release_ev            = 1'b0;
    rpt_ev                = 1'b0;
    if (item.mode == MODE_INIT) begin
      raw_level_next        = item.pin_level;
      stable_level_next     = item.pin_level;
      last_change_time_next = item.now_ms;
      press_time_next       = '0;
      last_repeat_time_next = '0;
    end else begin
      raw_level_next = item.pin_level;
      if (lvl_chg) begin
        last_change_time_next = item.now_ms;
      end
      if (settle) begin
        stable_level_next = item.pin_level;
        if (item.pin_level == cfg.active_level) begin
          press_ev              = 1'b1;
          press_time_next       = item.now_ms;
          last_repeat_time_next = item.now_ms;
        end else begin
          release_ev = 1'b1;
        end
      end
      // A fresh press counts both timers from zero
      if ((stable_level_next == cfg.active_level) &&
          ((press_ev ? '0 : since_press) >=
           {{(TIME_W-CFG_T_W){1'b0}}, cfg.long_press_time}) &&
          ((press_ev ? '0 : since_repeat) >=
           {{(TIME_W-CFG_T_W){1'b0}}, cfg.repeat_interval})) begin
        rpt_ev                = 1'b1;
        last_repeat_time_next = item.now_ms;
      end
    end
    res_next.pressed    = press_ev;
    res_next.released   = release_ev;
    res_next.repeat_res = rpt_ev;
    res_next.stable_out = stable_level_next;
  end

  // Advance state on each consumed request
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_level        <= 1'b0;
      stable_level     <= 1'b0;
      last_change_time <= '0;
      press_time       <= '0;
      last_repeat_time <= '0;
    end else if (ld) begin
      raw_level        <= raw_level_next;
      stable_level     <= stable_level_next;
      last_change_time <= last_change_time_next;
      press_time       <= press_time_next;
      last_repeat_time <= last_repeat_time_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res <= res_next;
    end
  end

  assign m_tdata = {{(M_TDATA_W-4){1'b0}}, res.stable_out, res.repeat_res,
                    res.released, res.pressed};

`ifndef SYNTH
  a_one_edge: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.pressed && res.released))
    else $error("press and release reported in one result");

  a_press_level: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res.pressed || res.repeat_res)) |-> (res.stable_out == cfg.active_level))
    else $error("press or repeat reported while not at the active level");

  a_stable_event: assert property (@(posedge clk) disable iff (rst)
    (ld && item.mode == MODE_UPDATE && stable_level_next != stable_level)
      |-> (press_ev || release_ev))
    else $error("debounced level moved without an event");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    ld |=> (m_tvalid && res.stable_out == stable_level))
    else $error("result not loaded after a request was consumed");
`endif

endmodule

### rtl/core/button_debounce_autorepeat_top.sv
// Top level of the button debouncer with auto-repeat.
// Depends on bdar_pkg, bdar_cfg_regs, bdar_in_reg and bdar_core.
//
//  channel  dir  handshake                 payload
//  -------  ---  ------------------------  -------------------------------------
//  s_*      in   s_tvalid / s_tready       tuser: mode; tdata: pin_level, now_ms
//  m_*      out  m_tvalid / m_tready       tdata: pressed, released, repeat_res,
//                                                 stable_out
//  apb      in   psel+penable, pready = 1  four settings registers at 4*i
//
// A request passes through the input register, then the state update and result
// register. One request is taken per cycle when the output is drained; state
// registers feed back into the next request directly.
// Synchronous reset clears state and valid flags and loads default settings.
// A stall on m_tready holds the result and backs up through the input register.
module button_debounce_autorepeat_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bdar_pkg::S_TDATA_W-1:0] s_tdata,  // [0] pin_level, [32:1] now_ms, rest 0
  input  logic                           s_tuser,  // [0] mode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bdar_pkg::M_TDATA_W-1:0] m_tdata,  // [0] pressed, [1] released,
                                                   // [2] repeat_res, [3] stable_out
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bdar_pkg::APB_AW-1:0]    paddr,
  input  logic [bdar_pkg::APB_DW-1:0]    pwdata,
  output logic [bdar_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import bdar_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  take;

  bdar_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdar_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  bdar_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

### verif/tb_button_debounce_autorepeat_top.sv
// Testbench for button_debounce_autorepeat_top: stream requests in, event results out.
// Predicts every result with its own debounce/repeat model held in a scoreboard class.
// Depends on bdar_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_button_debounce_autorepeat_top;
  import bdar_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;

  // Debounce and auto-repeat prediction, plus the queue of results still due
  class key_event_board;
    cfg_t              settings;
    logic              raw_lvl;
    logic              stable_lvl;
    logic [TIME_W-1:0] change_ms;
    logic [TIME_W-1:0] press_ms;
    logic [TIME_W-1:0] repeat_ms;
    result_t           due_q[$];
    int unsigned       fails;

    function new();
      settings.active_level    = RST_ACTIVE_LEVEL;
      settings.debounce_time   = RST_DEBOUNCE_TIME;
      settings.long_press_time = RST_LONG_PRESS_TIME;
      settings.repeat_interval = RST_REPEAT_INTERVAL;
      raw_lvl    = 1'b0;
      stable_lvl = 1'b0;
      change_ms  = '0;
      press_ms   = '0;
      repeat_ms  = '0;
      fails      = 0;
    endfunction

    // Mirror a register write; upper bits of the bus word are dropped
    function void set_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_ACTIVE_LEVEL:    settings.active_level    = value[0];
        REG_DEBOUNCE_TIME:   settings.debounce_time   = value[CFG_T_W-1:0];
        REG_LONG_PRESS_TIME: settings.long_press_time = value[CFG_T_W-1:0];
        REG_REPEAT_INTERVAL: settings.repeat_interval = value[CFG_T_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the button state with one accepted request and queue its result
    function void note_request(item_t req);
      result_t           res;
      logic [TIME_W-1:0] held_ms;
      logic [TIME_W-1:0] since_press;
      logic [TIME_W-1:0] since_repeat;
      res = '0;
      if (req.mode == MODE_INIT) begin
        raw_lvl    = req.pin_level;
        stable_lvl = req.pin_level;
        change_ms  = req.now_ms;
        press_ms   = '0;
        repeat_ms  = '0;
      end else begin
        // restart the debounce timer on any raw edge
        if (req.pin_level != raw_lvl) begin
          raw_lvl   = req.pin_level;
          change_ms = req.now_ms;
        end
        held_ms = req.now_ms - change_ms;
        if (held_ms >= settings.debounce_time && stable_lvl != raw_lvl) begin
          stable_lvl = raw_lvl;
          if (stable_lvl == settings.active_level) begin
            res.pressed = 1'b1;
            press_ms    = req.now_ms;
            repeat_ms   = req.now_ms;
          end else begin
            res.released = 1'b1;
          end
        end
        // auto-repeat while held past the long-press time
        since_press  = req.now_ms - press_ms;
        since_repeat = req.now_ms - repeat_ms;
        if (stable_lvl == settings.active_level &&
            since_press >= settings.long_press_time &&
            since_repeat >= settings.repeat_interval) begin
          res.repeat_res = 1'b1;
          repeat_ms      = req.now_ms;
        end
      end
      res.stable_out = stable_lvl;
      due_q.push_back(res);
    endfunction

    function void compare_bit(string name, logic want_b, logic seen_b);
      if (seen_b !== want_b) begin
        $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want_b, seen_b);
        fails++;
      end
    endfunction

    // Compare one received result against the oldest one due
    function void check_event(logic [M_TDATA_W-1:0] got);
      result_t want;
      result_t seen;
      if (due_q.size() == 0) begin
        $display("%0t: unrequested result, expected none, actual %h", $time, got);
        fails++;
        return;
      end
      want = due_q.pop_front();
      seen = result_t'(got[3:0]);
      compare_bit("pressed", want.pressed, seen.pressed);
      compare_bit("released", want.released, seen.released);
      compare_bit("repeat_res", want.repeat_res, seen.repeat_res);
      compare_bit("stable_out", want.stable_out, seen.stable_out);
      if (got[M_TDATA_W-1:4] !== '0) begin
        $display("%0t: tdata padding mismatch, expected 0, actual %h", $time,
                 got[M_TDATA_W-1:4]);
        fails++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  key_event_board board = new();
  bit                feed_idle = 1'b0;
  bit                drain_idle = 1'b0;
  logic [TIME_W-1:0] ms_clock = '0;
  logic              held_pin = 1'b0;
  int unsigned       bounces = 0;
  int unsigned       cycles = 0;

  button_debounce_autorepeat_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Drain results, with a random stall before each one when drain_idle is set
  initial begin : drain
    int unsigned hold;
    forever begin
      hold = drain_idle ? $urandom_range(0, 12) : 0;
      if (hold != 0) begin
        m_tready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      board.check_event(m_tdata);
      @(negedge clk);
    end
  end

  // Send one request, after a random gap when feed_idle is set; called and returns at a falling edge
  task automatic send_request(logic mode, logic pin, logic [TIME_W-1:0] now);
    item_t       req;
    int unsigned gap;
    req.mode      = mode;
    req.pin_level = pin;
    req.now_ms    = now;
    gap = feed_idle ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = req.mode;
    s_tdata  = {7'b0, req.now_ms, req.pin_level};
    do @(posedge clk); while (s_tready !== 1'b1);
    board.note_request(req);
    @(negedge clk);
  endtask

  // Hold off requests until every result is back, then settle
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (board.due_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one register through the bus; upper bits carry random junk
  task automatic write_setting(reg_idx_t idx, logic [APB_DW-1:0] value);
    int unsigned field_w;
    field_w = (idx == REG_ACTIVE_LEVEL) ? 1 : CFG_T_W;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = ($urandom << field_w) | value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    board.set_reg(idx, pwdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_all(logic act, int unsigned deb, int unsigned lng, int unsigned rep);
    write_setting(REG_ACTIVE_LEVEL, act);
    write_setting(REG_DEBOUNCE_TIME, deb);
    write_setting(REG_LONG_PRESS_TIME, lng);
    write_setting(REG_REPEAT_INTERVAL, rep);
  endtask

  // Time advance biased toward the current thresholds and just around them
  function automatic logic [TIME_W-1:0] pick_step();
    int unsigned deb;
    int unsigned lng;
    int unsigned rep;
    deb = board.settings.debounce_time;
    lng = board.settings.long_press_time;
    rep = board.settings.repeat_interval;
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return $urandom_range(0, deb);
      3: return deb;
      4: return $urandom_range(0, 1) ? deb + 1 : deb - (deb != 0);
      5: return rep;
      6: return $urandom_range(0, 1) ? rep + 1 : rep - (rep != 0);
      7: return lng;
      8: return $urandom_range(0, 2 * rep + 2);
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // Press/release sessions with contact bounce, rare inits and time jumps
  task automatic play_random(int unsigned count);
    int unsigned roll;
    logic        pin;
    logic        mode;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (bounces != 0) begin
        pin = 1'($urandom_range(0, 1));
        bounces--;
      end else begin
        if ($urandom_range(0, 11) == 0) begin
          held_pin = ~held_pin;
          bounces  = $urandom_range(0, 3);
        end
        pin = held_pin;
      end
      ms_clock = (roll < 2) ? $urandom : ms_clock + pick_step();
      mode     = (roll >= 97) ? MODE_INIT : MODE_UPDATE;
      send_request(mode, pin, ms_clock);
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: active low, so the button counts as held from time zero
    send_request(MODE_UPDATE, 1'b0, 32'd0);
    send_request(MODE_UPDATE, 1'b0, 32'd600);
    send_request(MODE_INIT, 1'b1, 32'd1000);
    send_request(MODE_UPDATE, 1'b0, 32'd1005);
    send_request(MODE_UPDATE, 1'b0, 32'd1025);
    send_request(MODE_UPDATE, 1'b0, 32'd1524);
    send_request(MODE_UPDATE, 1'b0, 32'd1525);
    send_request(MODE_UPDATE, 1'b0, 32'd1624);
    send_request(MODE_UPDATE, 1'b0, 32'd1625);
    // bounce before the release settles
    send_request(MODE_UPDATE, 1'b1, 32'd1630);
    send_request(MODE_UPDATE, 1'b0, 32'd1640);
    send_request(MODE_UPDATE, 1'b1, 32'd1645);
    send_request(MODE_UPDATE, 1'b1, 32'd1665);
    // held at init near the top of the time range, then wrap through zero
    send_request(MODE_INIT, 1'b0, 32'hFFFF_FFF0);
    send_request(MODE_UPDATE, 1'b0, 32'hFFFF_FFF5);
    send_request(MODE_UPDATE, 1'b1, 32'hFFFF_FFFA);
    send_request(MODE_UPDATE, 1'b1, 32'h0000_000E);
    send_request(MODE_UPDATE, 1'b1, 32'hFFFF_FFFF);
    send_request(MODE_INIT, 1'b1, 32'hFFFF_FFFF);
    wait_drained();

    // Zero times: press and repeat in one step, repeat on every step while held
    set_all(1'b1, 0, 0, 0);
    send_request(MODE_INIT, 1'b0, 32'd5);
    send_request(MODE_UPDATE, 1'b1, 32'd6);
    send_request(MODE_UPDATE, 1'b1, 32'd6);
    send_request(MODE_UPDATE, 1'b0, 32'd7);

    ms_clock   = 32'hFFFF_0000;
    feed_idle  = 1'b1;
    drain_idle = 1'b1;
    play_random(250);
    wait_drained();

    // Largest times
    set_all(1'b1, 65535, 65535, 65535);
    play_random(250);
    wait_drained();

    // Reset values again, no idling, with a full drain halfway
    set_all(1'b0, 20, 500, 100);
    feed_idle  = 1'b0;
    drain_idle = 1'b0;
    play_random(150);
    wait_drained();
    play_random(150);
    wait_drained();

    // Short times, sender gaps only
    set_all(1'b1, 5, 40, 10);
    feed_idle = 1'b1;
    play_random(300);
    wait_drained();

    // Random small times, receiver stalls only
    set_all(1'($urandom_range(0, 1)), $urandom_range(0, 40), $urandom_range(0, 300),
            $urandom_range(0, 60));
    feed_idle  = 1'b0;
    drain_idle = 1'b1;
    play_random(300);
    wait_drained();

    // Random full-range times
    set_all(1'($urandom_range(0, 1)), $urandom_range(0, 65535), $urandom_range(0, 65535),
            $urandom_range(0, 65535));
    feed_idle = 1'b1;
    play_random(300);
    wait_drained();

    repeat (10) @(negedge clk);
    if (board.fails == 0 && board.due_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
